// File: src/krt_pkg.sv
// Shared types, codes and helpers for the keepalive request tracker.
package krt_pkg;

    localparam int REC_DEFAULT = 8;
    localparam logic [62:0] TIMEOUT_RESET = 63'd5000000;

    localparam logic [2:0] CMD_START  = 3'd0;
    localparam logic [2:0] CMD_EXPIRE = 3'd1;
    localparam logic [2:0] CMD_RECV   = 3'd2;
    localparam logic [2:0] CMD_READ   = 3'd3;
    localparam logic [2:0] CMD_CLEAR  = 3'd4;

    localparam logic [2:0] ST_EMPTY     = 3'd0;
    localparam logic [2:0] ST_PENDING   = 3'd1;
    localparam logic [2:0] ST_TIMED_OUT = 3'd2;
    localparam logic [2:0] ST_MATCHED   = 3'd3;
    localparam logic [2:0] ST_LATE      = 3'd4;

    localparam logic [2:0] RES_OK      = 3'd0;
    localparam logic [2:0] RES_NO_SLOT = 3'd1;
    localparam logic [2:0] RES_MATCHED = 3'd2;
    localparam logic [2:0] RES_LATE    = 3'd3;
    localparam logic [2:0] RES_DUP     = 3'd4;
    localparam logic [2:0] RES_UNKNOWN = 3'd5;
    localparam logic [2:0] RES_REGRESS = 3'd6;

    localparam int STAT_COUNT = 10;
    localparam logic [3:0] SI_TX      = 4'd0;
    localparam logic [3:0] SI_RX      = 4'd1;
    localparam logic [3:0] SI_RESP    = 4'd2;
    localparam logic [3:0] SI_TIMEOUT = 4'd3;
    localparam logic [3:0] SI_LATE    = 4'd4;
    localparam logic [3:0] SI_DUP     = 4'd5;
    localparam logic [3:0] SI_UNKNOWN = 4'd6;
    localparam logic [3:0] SI_REGRESS = 4'd7;
    localparam logic [3:0] SI_TOTAL   = 4'd8;
    localparam logic [3:0] SI_LAST    = 4'd9;
    localparam logic [3:0] SI_PENDING = 4'd10;
    localparam logic [3:0] SI_AVERAGE = 4'd11;

    localparam logic [3:0] M_IDLE   = 4'd0;
    localparam logic [3:0] M_LOAD   = 4'd1;
    localparam logic [3:0] M_DISP   = 4'd2;
    localparam logic [3:0] M_PICK   = 4'd3;
    localparam logic [3:0] M_IDS    = 4'd4;
    localparam logic [3:0] M_WR     = 4'd5;
    localparam logic [3:0] M_NOSLOT = 4'd6;
    localparam logic [3:0] M_EXP    = 4'd7;
    localparam logic [3:0] M_FIND   = 4'd8;
    localparam logic [3:0] M_RCV    = 4'd9;
    localparam logic [3:0] M_DIV    = 4'd10;
    localparam logic [3:0] M_FIN    = 4'd11;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [63:0] now_us;
        logic [31:0] reply_id;
        logic [3:0]  stat_index;
    } krt_in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] assigned_id;
        logic [62:0] rtt_us;
        logic [63:0] stat_value;
    } krt_out_t;

    typedef struct packed {
        logic [3:0] mode;
    } krt_ctl_t;

    typedef struct packed {
        logic       idx_last;
        logic       id_hit;
        logic       rid_hit;
        logic       slot_ok;
        logic       div_last;
        logic       out_free;
        logic [2:0] cmd;
        logic       avg_sel;
    } krt_sts_t;

    function automatic logic [63:0] sat_inc(input logic [63:0] v);
        return (v == '1) ? v : v + 64'd1;
    endfunction

    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? '1 : s[63:0];
    endfunction

    function automatic logic [31:0] next_nz(input logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? 32'd1 : v + 32'd1;
    endfunction

endpackage

// File: src/krt_controller.sv
// Sequencer that steps the datapath through each command's scan phases.
module krt_controller (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  krt_pkg::krt_sts_t sts,
    output krt_pkg::krt_ctl_t ctl
);
    import krt_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DISP   = 4'd1;
    localparam logic [3:0] S_PICK   = 4'd2;
    localparam logic [3:0] S_IDS    = 4'd3;
    localparam logic [3:0] S_WR     = 4'd4;
    localparam logic [3:0] S_NOSLOT = 4'd5;
    localparam logic [3:0] S_EXP    = 4'd6;
    localparam logic [3:0] S_FIND   = 4'd7;
    localparam logic [3:0] S_RCV    = 4'd8;
    localparam logic [3:0] S_DIV    = 4'd9;
    localparam logic [3:0] S_FIN    = 4'd10;

    logic [3:0] state_reg, state_next;

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        ctl.mode = M_IDLE;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    ctl.mode = M_LOAD;
                    state_next = S_DISP;
                end
            end
            S_DISP: begin
                ctl.mode = M_DISP;
                case (sts.cmd)
                    CMD_START:  state_next = S_PICK;
                    CMD_EXPIRE: state_next = S_EXP;
                    CMD_RECV:   state_next = S_EXP;
                    CMD_READ:   state_next = sts.avg_sel ? S_DIV : S_FIN;
                    default:    state_next = S_FIN;
                endcase
            end
            S_PICK: begin
                ctl.mode = M_PICK;
                if (sts.idx_last) state_next = sts.slot_ok ? S_IDS : S_NOSLOT;
            end
            S_IDS: begin
                ctl.mode = M_IDS;
                if (!sts.id_hit && sts.idx_last) state_next = S_WR;
            end
            S_WR: begin
                ctl.mode = M_WR;
                state_next = S_FIN;
            end
            S_NOSLOT: begin
                ctl.mode = M_NOSLOT;
                state_next = S_FIN;
            end
            S_EXP: begin
                ctl.mode = M_EXP;
                if (sts.idx_last) state_next = (sts.cmd == CMD_RECV) ? S_FIND : S_FIN;
            end
            S_FIND: begin
                ctl.mode = M_FIND;
                if (sts.rid_hit || sts.idx_last) state_next = S_RCV;
            end
            S_RCV: begin
                ctl.mode = M_RCV;
                state_next = S_FIN;
            end
            S_DIV: begin
                ctl.mode = M_DIV;
                if (sts.div_last) state_next = S_FIN;
            end
            S_FIN: begin
                ctl.mode = M_FIN;
                if (sts.out_free) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// File: src/krt_datapath.sv
// Record table, statistics, average divider and result register.
module krt_datapath #(
    parameter int RECORDS = krt_pkg::REC_DEFAULT
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  krt_pkg::krt_ctl_t ctl,
    output krt_pkg::krt_sts_t sts,
    input  krt_pkg::krt_in_t  s_data,
    input  logic              cfg_wr_en,
    input  logic [62:0]       cfg_wr_data,
    output logic              m_valid,
    input  logic              m_ready,
    output krt_pkg::krt_out_t m_data
);
    import krt_pkg::*;

    localparam int IW = (RECORDS > 1) ? $clog2(RECORDS) : 1;
    localparam int PW = $clog2(RECORDS + 1);
    localparam logic [IW-1:0] IDX_LAST = IW'(RECORDS - 1);

    krt_in_t     in_reg;
    logic [31:0] rec_id_reg    [RECORDS];
    logic [63:0] rec_start_reg [RECORDS];
    logic [2:0]  rec_st_reg    [RECORDS];
    logic [31:0] rec_age_reg   [RECORDS];
    logic [63:0] stat_reg      [STAT_COUNT];
    logic [IW-1:0] idx_reg, slot_reg, fidx_reg;
    logic [31:0] last_id_reg, age_reg, cand_reg, best_age_reg;
    logic [PW-1:0] pend_reg;
    logic [62:0] timeout_reg;
    logic        empty_found_reg, slot_ok_reg, found_reg;
    logic [2:0]  fst_reg;
    logic [63:0] fd_reg;
    logic [63:0] q_reg;
    logic [64:0] rem_reg;
    logic [5:0]  cnt_reg;
    krt_out_t    res_reg;
    logic        m_valid_reg;
    krt_out_t    m_data_reg;

    logic [2:0]  cur_st;
    logic [63:0] d;
    logic        exp_hit, id_hit, rid_hit, idx_last, out_free;
    logic [31:0] age_inc;
    logic [IW-1:0] idx_next;
    logic        st_we;
    logic [IW-1:0] st_widx;
    logic [2:0]  st_wval;
    logic [64:0] rem_sh;
    logic        div_ge;
    logic [63:0] q_next;
    logic [64:0] rem_next;

    assign cur_st   = rec_st_reg[idx_reg];
    assign d        = in_reg.now_us - rec_start_reg[idx_reg];
    assign exp_hit  = (cur_st == ST_PENDING) && !d[63] && (d >= {1'b0, timeout_reg});
    assign id_hit   = (cur_st != ST_EMPTY) && (rec_id_reg[idx_reg] == cand_reg);
    assign rid_hit  = (cur_st != ST_EMPTY) && (rec_id_reg[idx_reg] == in_reg.reply_id);
    assign idx_last = (idx_reg == IDX_LAST);
    assign idx_next = idx_last ? '0 : idx_reg + 1'b1;
    assign age_inc  = next_nz(age_reg);
    assign out_free = !m_valid_reg || m_ready;

    assign rem_sh   = {rem_reg[63:0], q_reg[63]};
    assign div_ge   = rem_sh >= {1'b0, stat_reg[SI_RX]};
    assign rem_next = div_ge ? rem_sh - {1'b0, stat_reg[SI_RX]} : rem_sh;
    assign q_next   = {q_reg[62:0], div_ge};

    assign sts.idx_last = idx_last;
    assign sts.id_hit   = id_hit;
    assign sts.rid_hit  = rid_hit;
    assign sts.slot_ok  = slot_ok_reg || (cur_st != ST_PENDING);
    assign sts.div_last = (cnt_reg == 6'd63);
    assign sts.out_free = out_free;
    assign sts.cmd      = in_reg.cmd;
    assign sts.avg_sel  = (in_reg.stat_index == SI_AVERAGE);

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Record state writes: one record per cycle at most.
    always_comb begin
        st_we   = 1'b0;
        st_widx = idx_reg;
        st_wval = ST_PENDING;
        case (ctl.mode)
            M_WR: begin
                st_we   = 1'b1;
                st_widx = slot_reg;
            end
            M_EXP: begin
                st_we   = exp_hit;
                st_wval = ST_TIMED_OUT;
            end
            M_RCV: begin
                st_widx = fidx_reg;
                if (found_reg && fst_reg == ST_PENDING && !fd_reg[63]) begin
                    st_we   = 1'b1;
                    st_wval = ST_MATCHED;
                end else if (found_reg && fst_reg == ST_TIMED_OUT) begin
                    st_we   = 1'b1;
                    st_wval = ST_LATE;
                end
            end
            default: st_we = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < RECORDS; i++) rec_st_reg[i] <= ST_EMPTY;
            for (int k = 0; k < STAT_COUNT; k++) stat_reg[k] <= '0;
            last_id_reg <= '0;
            age_reg     <= '0;
            pend_reg    <= '0;
            timeout_reg <= TIMEOUT_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) timeout_reg <= cfg_wr_data;
            if (st_we) begin
                rec_st_reg[st_widx] <= st_wval;
                age_reg <= age_inc;
            end
            case (ctl.mode)
                M_LOAD: begin
                    if (s_data.cmd == CMD_CLEAR) begin
                        for (int i = 0; i < RECORDS; i++) rec_st_reg[i] <= ST_EMPTY;
                        for (int k = 0; k < STAT_COUNT; k++) stat_reg[k] <= '0;
                        last_id_reg <= '0;
                        age_reg     <= '0;
                        pend_reg    <= '0;
                    end
                end
                M_WR: begin
                    last_id_reg <= cand_reg;
                    pend_reg    <= pend_reg + 1'b1;
                    stat_reg[SI_TX] <= sat_inc(stat_reg[SI_TX]);
                end
                M_EXP: begin
                    if (exp_hit) begin
                        if (pend_reg != '0) pend_reg <= pend_reg - 1'b1;
                        stat_reg[SI_TIMEOUT] <= sat_inc(stat_reg[SI_TIMEOUT]);
                    end
                end
                M_RCV: begin
                    if (!found_reg) begin
                        stat_reg[SI_UNKNOWN] <= sat_inc(stat_reg[SI_UNKNOWN]);
                    end else if (fst_reg == ST_PENDING) begin
                        if (fd_reg[63]) begin
                            stat_reg[SI_REGRESS] <= sat_inc(stat_reg[SI_REGRESS]);
                        end else begin
                            if (pend_reg != '0) pend_reg <= pend_reg - 1'b1;
                            stat_reg[SI_RX]    <= sat_inc(stat_reg[SI_RX]);
                            stat_reg[SI_RESP]  <= sat_inc(stat_reg[SI_RESP]);
                            stat_reg[SI_TOTAL] <= sat_add(stat_reg[SI_TOTAL], fd_reg);
                            stat_reg[SI_LAST]  <= fd_reg;
                        end
                    end else if (fst_reg == ST_TIMED_OUT) begin
                        stat_reg[SI_LATE] <= sat_inc(stat_reg[SI_LATE]);
                        stat_reg[SI_RESP] <= sat_inc(stat_reg[SI_RESP]);
                    end else begin
                        stat_reg[SI_DUP] <= sat_inc(stat_reg[SI_DUP]);
                    end
                end
                default: ;
            endcase
            if (ctl.mode == M_FIN && out_free) m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
        end
    end

    // Payload: record fields, scan trackers, divider and result.
    always_ff @(posedge aclk) begin
        if (st_we) rec_age_reg[st_widx] <= age_inc;
        if (ctl.mode == M_FIN && out_free) m_data_reg <= res_reg;
        case (ctl.mode)
            M_LOAD: begin
                in_reg          <= s_data;
                idx_reg         <= '0;
                empty_found_reg <= 1'b0;
                slot_ok_reg     <= 1'b0;
                found_reg       <= 1'b0;
                res_reg         <= '0;
                q_reg           <= stat_reg[SI_TOTAL];
                rem_reg         <= '0;
                cnt_reg         <= '0;
                if (s_data.cmd == CMD_READ) begin
                    if (s_data.stat_index < SI_PENDING)
                        res_reg.stat_value <= stat_reg[s_data.stat_index];
                    else if (s_data.stat_index == SI_PENDING)
                        res_reg.stat_value <= 64'(pend_reg);
                end
            end
            M_PICK: begin
                cand_reg <= next_nz(last_id_reg);
                idx_reg  <= idx_next;
                if (!empty_found_reg) begin
                    if (cur_st == ST_EMPTY) begin
                        empty_found_reg <= 1'b1;
                        slot_ok_reg     <= 1'b1;
                        slot_reg        <= idx_reg;
                    end else if (cur_st != ST_PENDING &&
                                 (!slot_ok_reg || rec_age_reg[idx_reg] < best_age_reg)) begin
                        slot_ok_reg  <= 1'b1;
                        slot_reg     <= idx_reg;
                        best_age_reg <= rec_age_reg[idx_reg];
                    end
                end
            end
            M_IDS: begin
                // restart the scan with the next id on a collision
                if (id_hit) begin
                    cand_reg <= next_nz(cand_reg);
                    idx_reg  <= '0;
                end else begin
                    idx_reg <= idx_next;
                end
            end
            M_WR: begin
                rec_id_reg[slot_reg]    <= cand_reg;
                rec_start_reg[slot_reg] <= in_reg.now_us;
                res_reg.assigned_id     <= cand_reg;
            end
            M_NOSLOT: res_reg.status <= RES_NO_SLOT;
            M_EXP:    idx_reg <= idx_next;
            M_FIND: begin
                idx_reg <= idx_next;
                if (rid_hit) begin
                    found_reg <= 1'b1;
                    fidx_reg  <= idx_reg;
                    fst_reg   <= cur_st;
                    fd_reg    <= d;
                end
            end
            M_RCV: begin
                if (!found_reg) begin
                    res_reg.status <= RES_UNKNOWN;
                end else if (fst_reg == ST_PENDING) begin
                    if (fd_reg[63]) begin
                        res_reg.status <= RES_REGRESS;
                    end else begin
                        res_reg.status <= RES_MATCHED;
                        res_reg.rtt_us <= fd_reg[62:0];
                    end
                end else if (fst_reg == ST_TIMED_OUT) begin
                    res_reg.status <= RES_LATE;
                end else begin
                    res_reg.status <= RES_DUP;
                end
            end
            M_DIV: begin
                q_reg   <= q_next;
                rem_reg <= rem_next;
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                    res_reg.stat_value <= (stat_reg[SI_RX] == '0) ? '0 : q_next;
            end
            default: ;
        endcase
    end

endmodule

// File: src/keepalive_request_tracker_unit.sv
// Top level of the keepalive request tracker: controller plus datapath.
//
//  channel  ports                        payload
//  input    s_valid / s_ready / s_data   krt_in_t  (cmd, now_us, reply_id, stat_index)
//  result   m_valid / m_ready / m_data   krt_out_t (status, assigned_id, rtt_us, stat_value)
//  config   cfg_wr_en / cfg_wr_data      timeout_us, 63 bits
//
// One command at a time. Start scans for a slot, then scans the ids, restarting on each
// collision, with records scanned one per cycle through a single table read port; expire
// makes one expiry scan; receive makes the expiry scan and then a search for the reply id;
// the average read runs a 64-step restoring divider. A finished result waits in the output
// register; the next command is taken while it waits, and a second result holds until it
// is taken. aresetn is synchronous, active low, and empties the table at once.
module keepalive_request_tracker_unit #(
    parameter int RECORDS = krt_pkg::REC_DEFAULT
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  krt_pkg::krt_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output krt_pkg::krt_out_t m_data,
    input  logic              cfg_wr_en,
    input  logic [62:0]       cfg_wr_data
);
    import krt_pkg::*;

    krt_ctl_t ctl;
    krt_sts_t sts;

    krt_controller u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .ctl     (ctl)
    );

    krt_datapath #(.RECORDS(RECORDS)) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctl         (ctl),
        .sts         (sts),
        .s_data      (s_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule

// File: tb/sv/keepalive_request_tracker_unit_test.sv
// Self-checking testbench for the keepalive request tracker unit.
module keepalive_request_tracker_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import krt_pkg::*;

    localparam int NREC = 8;
    localparam longint unsigned CYCLE_LIMIT = 2000000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    krt_in_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    krt_out_t m_data;
    logic cfg_wr_en = 1'b0;
    logic [62:0] cfg_wr_data = '0;

    keepalive_request_tracker_unit #(.RECORDS(NREC)) u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // tracker state mirror
    logic [62:0] tmo;
    logic [31:0] r_id [NREC];
    logic [63:0] r_t0 [NREC];
    logic [2:0]  r_st [NREC];
    logic [31:0] r_age [NREC];
    logic [31:0] last_id, age_ctr;
    logic [3:0]  n_pend;
    logic [63:0] stats [10];

    krt_in_t  cmd_queue[$];
    krt_out_t result_queue[$];
    int errors = 0;
    longint unsigned cycles = 0;
    bit idle_en = 1'b1;
    bit hold_off = 1'b0;

    function automatic void clear_tracker();
        for (int i = 0; i < NREC; i++) begin
            r_id[i] = '0; r_t0[i] = '0; r_st[i] = ST_EMPTY; r_age[i] = '0;
        end
        last_id = '0; age_ctr = '0; n_pend = '0;
        for (int k = 0; k < 10; k++) stats[k] = '0;
    endfunction

    function automatic void inc_stat(int k);
        if (stats[k] != '1) stats[k] = stats[k] + 64'd1;
    endfunction

    function automatic void touch(int i);
        age_ctr = age_ctr + 32'd1;
        if (age_ctr == 0) age_ctr = 32'd1;
        r_age[i] = age_ctr;
    endfunction

    function automatic int lookup(logic [31:0] id);
        for (int i = 0; i < NREC; i++)
            if (r_st[i] != ST_EMPTY && r_id[i] == id) return i;
        return -1;
    endfunction

    function automatic void run_expiry(logic [63:0] now);
        logic [63:0] d;
        for (int i = 0; i < NREC; i++) begin
            d = now - r_t0[i];
            if (r_st[i] == ST_PENDING && !d[63] && d >= {1'b0, tmo}) begin
                r_st[i] = ST_TIMED_OUT;
                touch(i);
                if (n_pend > 0) n_pend = n_pend - 4'd1;
                inc_stat(SI_TIMEOUT);
            end
        end
    endfunction

    function automatic krt_out_t track_command(krt_in_t c);
        krt_out_t o;
        int s, r;
        logic [31:0] cand;
        logic [63:0] d;
        logic [64:0] sum;
        o = '0;
        case (c.cmd)
            CMD_START: begin
                s = -1;
                for (int i = 0; i < NREC; i++) begin
                    if (r_st[i] == ST_EMPTY) begin s = i; break; end
                    if (r_st[i] != ST_PENDING && (s < 0 || r_age[i] < r_age[s])) s = i;
                end
                if (s < 0) o.status = RES_NO_SLOT;
                else begin
                    cand = last_id;
                    for (int a = 0; a <= NREC; a++) begin
                        cand = cand + 32'd1;
                        if (cand == 0) cand = 32'd1;
                        if (lookup(cand) < 0) break;
                    end
                    last_id = cand;
                    r_id[s] = cand; r_t0[s] = c.now_us; r_st[s] = ST_PENDING;
                    touch(s);
                    n_pend = n_pend + 4'd1;
                    inc_stat(SI_TX);
                    o.assigned_id = cand;
                end
            end
            CMD_EXPIRE: run_expiry(c.now_us);
            CMD_RECV: begin
                run_expiry(c.now_us);
                r = lookup(c.reply_id);
                if (r < 0) begin
                    inc_stat(SI_UNKNOWN); o.status = RES_UNKNOWN;
                end else if (r_st[r] == ST_PENDING) begin
                    d = c.now_us - r_t0[r];
                    if (d[63]) begin
                        inc_stat(SI_REGRESS); o.status = RES_REGRESS;
                    end else begin
                        r_st[r] = ST_MATCHED;
                        touch(r);
                        if (n_pend > 0) n_pend = n_pend - 4'd1;
                        inc_stat(SI_RX); inc_stat(SI_RESP);
                        sum = {1'b0, stats[SI_TOTAL]} + {1'b0, d};
                        stats[SI_TOTAL] = sum[64] ? '1 : sum[63:0];
                        stats[SI_LAST] = d;
                        o.rtt_us = d[62:0];
                        o.status = RES_MATCHED;
                    end
                end else if (r_st[r] == ST_TIMED_OUT) begin
                    r_st[r] = ST_LATE;
                    touch(r);
                    inc_stat(SI_LATE); inc_stat(SI_RESP);
                    o.status = RES_LATE;
                end else begin
                    inc_stat(SI_DUP); o.status = RES_DUP;
                end
            end
            CMD_READ: begin
                if (c.stat_index < 4'd10) o.stat_value = stats[c.stat_index];
                else if (c.stat_index == SI_PENDING) o.stat_value = {60'd0, n_pend};
                else if (c.stat_index == SI_AVERAGE)
                    o.stat_value = (stats[SI_RX] != 0) ? stats[SI_TOTAL] / stats[SI_RX] : '0;
            end
            CMD_CLEAR: clear_tracker();
            default: ;
        endcase
        return o;
    endfunction

    // driver
    always @(posedge aclk) begin
        if (aresetn) begin
            if (!s_valid || s_ready) begin
                if (cmd_queue.size() > 0 && (!idle_en || $urandom_range(99) >= 30)) begin
                    s_valid <= 1'b1;
                    s_data <= cmd_queue[0];
                    result_queue.push_back(track_command(cmd_queue.pop_front()));
                end else s_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (result_queue.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, m_data);
                    errors = errors + 1;
                end else begin
                    if (m_data.status !== result_queue[0].status) begin
                        $display("%0t: status expected %0d actual %0d", $time,
                                 result_queue[0].status, m_data.status);
                        errors = errors + 1;
                    end
                    if (m_data.assigned_id !== result_queue[0].assigned_id) begin
                        $display("%0t: assigned_id expected %0d actual %0d", $time,
                                 result_queue[0].assigned_id, m_data.assigned_id);
                        errors = errors + 1;
                    end
                    if (m_data.rtt_us !== result_queue[0].rtt_us) begin
                        $display("%0t: rtt_us expected %0d actual %0d", $time,
                                 result_queue[0].rtt_us, m_data.rtt_us);
                        errors = errors + 1;
                    end
                    if (m_data.stat_value !== result_queue[0].stat_value) begin
                        $display("%0t: stat_value expected %0d actual %0d", $time,
                                 result_queue[0].stat_value, m_data.stat_value);
                        errors = errors + 1;
                    end
                    void'(result_queue.pop_front());
                end
            end
            m_ready <= !hold_off && (!idle_en || $urandom_range(99) >= 30);
        end
    end

    always @(posedge aclk) begin
        if (cycles >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // receiver hold-off: block fills and stalls its input
    initial begin
        repeat (3000) @(posedge aclk);
        hold_off = 1'b1;
        repeat (400) @(posedge aclk);
        hold_off = 1'b0;
    end

    function automatic krt_in_t mk(logic [2:0] c, logic [63:0] t, logic [31:0] id,
                                   logic [3:0] si);
        krt_in_t x;
        x.cmd = c; x.now_us = t; x.reply_id = id; x.stat_index = si;
        return x;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [31:0] last_id_guess();
        return $urandom_range(40);
    endfunction

    task automatic drain();
        while (cmd_queue.size() > 0 || result_queue.size() > 0 || s_valid)
            @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    task automatic write_timeout(logic [62:0] v);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        tmo = v;
    endtask

    // mostly session-like traffic near a moving clock
    task automatic random_phase(int n, logic [63:0] base, int span);
        logic [63:0] t;
        int k;
        t = base;
        for (int i = 0; i < n; i++) begin
            t = t + 64'($urandom_range(span));
            k = $urandom_range(99);
            if (k < 30)
                cmd_queue.push_back(mk(CMD_START, t, 32'(rand64()), 4'($urandom())));
            else if (k < 55)
                cmd_queue.push_back(mk(CMD_RECV, t, last_id_guess(), 4'($urandom())));
            else if (k < 62)
                cmd_queue.push_back(mk(CMD_EXPIRE, t, $urandom(), 4'($urandom())));
            else if (k < 80)
                cmd_queue.push_back(mk(CMD_READ, t, $urandom(), 4'($urandom())));
            else if (k < 82)
                cmd_queue.push_back(mk(CMD_CLEAR, t, $urandom(), 4'($urandom())));
            else if (k < 85)
                cmd_queue.push_back(mk(3'($urandom_range(7, 5)), rand64(), $urandom(),
                                       4'($urandom())));
            else if (k < 90)
                cmd_queue.push_back(mk(CMD_RECV, rand64(), $urandom(), 4'd0));
            else if (k < 93)
                cmd_queue.push_back(mk(CMD_START, rand64(), 32'd0, 4'd0));
            else
                cmd_queue.push_back(mk(CMD_RECV, t - 64'($urandom_range(50)),
                                       $urandom_range(40), 4'd0));
        end
    endtask

    initial begin
        tmo = TIMEOUT_RESET;
        clear_tracker();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: fill table, no slot, match, regression, late, duplicate, unknown
        for (int i = 0; i < 9; i++)
            cmd_queue.push_back(mk(CMD_START, 64'd100 + 64'(i), 32'd0, 4'd0));
        cmd_queue.push_back(mk(CMD_RECV, 64'd300, 32'd1, 4'd0));
        cmd_queue.push_back(mk(CMD_RECV, 64'd301, 32'd1, 4'd0));
        cmd_queue.push_back(mk(CMD_RECV, 64'd50, 32'd2, 4'd0));
        cmd_queue.push_back(mk(CMD_RECV, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 4'd0));
        cmd_queue.push_back(mk(CMD_EXPIRE, 64'd6000000, 32'd0, 4'd0));
        cmd_queue.push_back(mk(CMD_RECV, 64'd6000001, 32'd3, 4'd0));
        cmd_queue.push_back(mk(CMD_START, 64'd6000002, 32'd0, 4'd0));
        for (int s = 0; s < 16; s++) cmd_queue.push_back(mk(CMD_READ, 64'd0, 32'd0, 4'(s)));
        drain();

        write_timeout(63'd0);
        random_phase(200, 64'd0, 10);
        drain();
        write_timeout('1);
        random_phase(200, 64'hFFFF_FFFF_FFFF_0000, 100000);
        drain();
        write_timeout(63'd1);
        idle_en = 1'b0;
        random_phase(300, rand64(), 3);
        drain();
        idle_en = 1'b1;
        write_timeout(63'd40);
        random_phase(1200, rand64(), 20);
        drain();

        if (errors == 0) $display("Simulation PASSED");
        else $display("Simulation FAILED");
        $finish;
    end

endmodule
